// ----- rtl/page_table_map_walker_top_defines.svh -----
// ---------------------------------------------------------------------------
// page_table_map_walker_top_defines
// Assertion macros used by the page table map walker sequencer.
// ---------------------------------------------------------------------------
`ifndef PAGE_TABLE_MAP_WALKER_TOP_DEFINES_SVH
`define PAGE_TABLE_MAP_WALKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define PTMW_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptmw assertion failed");
// antecedent implies consequent in the next cycle
`define PTMW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptmw assertion failed");
`else
`define PTMW_ASSERT_SAME(label, clk, rst, ante, cons)
`define PTMW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/ptmw_pkg.sv -----
// ---------------------------------------------------------------------------
// ptmw_pkg
// Shared constants, types and helper functions of the page table map walker.
// ---------------------------------------------------------------------------
package ptmw_pkg;

   localparam int POOL_FRAMES_DEF = 64;

   localparam int VA_W        = 57;
   localparam int PA_W        = 52;
   localparam int PROT_W      = 3;
   localparam int ENTRY_W     = 64;
   localparam int BASE_W      = 40;
   localparam int CFG_FRAMES_W = 7;
   localparam int USED_W      = 7;
   localparam int SLICE_W     = 9;
   localparam int ENTRIES     = 512;
   localparam int LEVEL_W     = 3;
   localparam int CSR_IDX_W   = 2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIVE_LEVEL  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_FRAMES = 2'd2;

   localparam logic [CFG_FRAMES_W-1:0] POOL_FRAMES_RST = 7'd64;

   // walk levels
   localparam logic [LEVEL_W-1:0] LVL_LEAF = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_2    = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_3    = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_4    = 3'd4;
   localparam logic [LEVEL_W-1:0] LVL_5    = 3'd5;

   // protection codes
   localparam logic [PROT_W-1:0] PROT_RO      = 3'd0;
   localparam logic [PROT_W-1:0] PROT_RW      = 3'd1;
   localparam logic [PROT_W-1:0] PROT_EXEC_RW = 3'd2;
   localparam logic [PROT_W-1:0] PROT_EXEC_RO = 3'd3;

   // entry flags
   localparam logic [ENTRY_W-1:0] F_P  = 64'h0000_0000_0000_0001;
   localparam logic [ENTRY_W-1:0] F_RW = 64'h0000_0000_0000_0002;
   localparam logic [ENTRY_W-1:0] F_US = 64'h0000_0000_0000_0004;
   localparam logic [ENTRY_W-1:0] F_NX = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic load;
      logic clear_wr;
      logic follow;
      logic alloc;
      logic fail;
      logic leaf_wr;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic present;
      logic rel_ok;
      logic alloc_ok;
      logic last_level;
   } stat_type;

   function automatic logic [ENTRY_W-1:0] prot_flags(input logic [PROT_W-1:0] prot);
      logic [ENTRY_W-1:0] flags;
      case (prot)
         PROT_RO:      flags = F_P | F_NX;
         PROT_RW:      flags = F_P | F_RW | F_NX;
         PROT_EXEC_RW: flags = F_P | F_RW;
         PROT_EXEC_RO: flags = F_P;
         default:      flags = '0;
      endcase
      return flags;
   endfunction

   function automatic logic [SLICE_W-1:0] va_slice(input logic [VA_W-1:0] va,
                                                   input logic [LEVEL_W-1:0] level);
      logic [SLICE_W-1:0] s;
      case (level)
         LVL_LEAF: s = va[20:12];
         LVL_2:    s = va[29:21];
         LVL_3:    s = va[38:30];
         LVL_4:    s = va[47:39];
         LVL_5:    s = va[56:48];
         default:  s = va[20:12];
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/ptmw_datapath.sv -----
// ---------------------------------------------------------------------------
// ptmw_datapath
// Table store, allocation counter, walk registers and configuration.
// ---------------------------------------------------------------------------
module ptmw_datapath
   import ptmw_pkg::*;
#(
   parameter int POOL_FRAMES = POOL_FRAMES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output stat_type                stat,
   input  logic [VA_W-1:0]         req_virt_addr,
   input  logic [PA_W-1:0]         req_phys_addr,
   input  logic [PROT_W-1:0]       req_protection,
   input  logic                    csr_valid,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [BASE_W-1:0]       csr_wdata,
   output logic                    rsp_status,
   output logic [ENTRY_W-1:0]      rsp_leaf_entry,
   output logic [USED_W-1:0]       rsp_frames_used
);

   localparam int FW    = $clog2(POOL_FRAMES);
   localparam int AW    = FW + SLICE_W;
   localparam int DEPTH = POOL_FRAMES * ENTRIES;
   localparam int CW    = $clog2(POOL_FRAMES + 1);
   localparam int CMPW  = (CW > CFG_FRAMES_W) ? CW : CFG_FRAMES_W;
   localparam int MW    = ENTRY_W + 1;

   // each word carries a tag: set when written while its frame was allocated,
   // or by the write that allocates its own frame
   logic [MW-1:0] mem [DEPTH];
   logic [MW-1:0] rdata_ff;

   logic                    five_level_ff;
   logic [BASE_W-1:0]       base_ff;
   logic [CFG_FRAMES_W-1:0] cfg_frames_ff;

   logic [VA_W-1:0]    va_ff;
   logic [PA_W-1:0]    pa_ff;
   logic [PROT_W-1:0]  prot_ff;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [FW-1:0]      frame_ff, frame_in;
   logic [CW-1:0]      next_free_ff, next_free_in;
   logic [AW-1:0]      clr_cnt_ff;
   logic               status_ff, status_in;
   logic [ENTRY_W-1:0] leaf_ff, leaf_in;

   logic [AW-1:0]      pos;
   logic               frame_alloc;
   logic [ENTRY_W-1:0] entry;
   logic [BASE_W:0]    rel;
   logic [BASE_W-1:0]  new_frame_num;
   logic [ENTRY_W-1:0] new_entry;
   logic [ENTRY_W-1:0] leaf_val;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [MW-1:0]      mem_wdata;

   assign pos         = {frame_ff, va_slice(va_ff, level_ff)};
   assign frame_alloc = CW'(frame_ff) < next_free_ff;

   // a frame allocated after the word was written reads as cleared
   assign entry = (rdata_ff[MW-1] || !frame_alloc) ? rdata_ff[ENTRY_W-1:0] : '0;

   assign rel           = {1'b0, entry[51:12]} - {1'b0, base_ff};
   assign new_frame_num = base_ff + BASE_W'(next_free_ff);
   assign new_entry     = {12'b0, new_frame_num, 12'b0} | F_P | F_RW | F_US;
   assign leaf_val      = {12'b0, pa_ff} | prot_flags(prot_ff);

   assign stat.clear_done = clr_cnt_ff == AW'(DEPTH - 1);
   assign stat.present    = entry[0];
   assign stat.rel_ok     = !rel[BASE_W] && (rel[BASE_W-1:0] < BASE_W'(POOL_FRAMES));
   assign stat.alloc_ok   = (CMPW'(next_free_ff) < CMPW'(cfg_frames_ff)) &&
                            (next_free_ff < CW'(POOL_FRAMES));
   assign stat.last_level = level_ff == LVL_2;

   always_comb begin
      mem_we    = cmd.clear_wr | cmd.alloc | cmd.leaf_wr;
      mem_waddr = cmd.clear_wr ? clr_cnt_ff : pos;
      if (cmd.clear_wr) begin
         mem_wdata = '0;
      end else if (cmd.alloc) begin
         // the new frame is cleared before its entry lands, even in its own table
         mem_wdata = {frame_alloc || (CW'(frame_ff) == next_free_ff), new_entry};
      end else begin
         mem_wdata = {frame_alloc, leaf_val};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[pos];
   end

   always_comb begin
      level_in     = level_ff;
      frame_in     = frame_ff;
      next_free_in = next_free_ff;
      status_in    = status_ff;
      leaf_in      = leaf_ff;
      if (cmd.load) begin
         level_in  = five_level_ff ? LVL_5 : LVL_4;
         frame_in  = '0;
         status_in = 1'b0;
         leaf_in   = '0;
      end
      if (cmd.follow) begin
         level_in = level_ff - LEVEL_W'(1);
         frame_in = rel[FW-1:0];
      end
      if (cmd.alloc) begin
         level_in     = level_ff - LEVEL_W'(1);
         frame_in     = next_free_ff[FW-1:0];
         next_free_in = next_free_ff + CW'(1);
      end
      if (cmd.fail) begin
         status_in = 1'b1;
      end
      if (cmd.leaf_wr) begin
         leaf_in = leaf_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         five_level_ff <= 1'b0;
         base_ff       <= '0;
         cfg_frames_ff <= POOL_FRAMES_RST;
         next_free_ff  <= CW'(1);
         clr_cnt_ff    <= '0;
         status_ff     <= 1'b0;
         leaf_ff       <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_FIVE_LEVEL:  five_level_ff <= csr_wdata[0];
               CSR_POOL_BASE:   base_ff       <= csr_wdata;
               CSR_POOL_FRAMES: cfg_frames_ff <= csr_wdata[CFG_FRAMES_W-1:0];
               default: ;
            endcase
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         next_free_ff <= next_free_in;
         status_ff    <= status_in;
         leaf_ff      <= leaf_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      frame_ff <= frame_in;
      if (cmd.load) begin
         va_ff   <= req_virt_addr;
         pa_ff   <= req_phys_addr;
         prot_ff <= req_protection;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_leaf_entry  = leaf_ff;
   assign rsp_frames_used = USED_W'(next_free_ff);

endmodule

// ----- rtl/ptmw_ctrl.sv -----
// ---------------------------------------------------------------------------
// ptmw_ctrl
// Walk sequencer: clearing pass, level by level lookup, leaf write, result.
// ---------------------------------------------------------------------------
`include "page_table_map_walker_top_defines.svh"

module ptmw_ctrl
   import ptmw_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   output logic     rsp_valid,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_EVAL  = 6'b001000,
      ST_LEAF  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.present ? !stat.rel_ok : !stat.alloc_ok) begin
               cmd.fail = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.follow = stat.present;
               cmd.alloc  = !stat.present;
               state_in   = stat.last_level ? ST_LEAF : ST_READ;
            end
         end
         ST_LEAF: begin
            cmd.leaf_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_DONE;

   `PTMW_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `PTMW_ASSERT_SAME(a_alloc_room, clock, reset, cmd.alloc, stat.alloc_ok)
   `PTMW_ASSERT_NEXT(a_load_reads, clock, reset, cmd.load, state_ff == ST_READ)
   `PTMW_ASSERT_SAME(a_one_step, clock, reset, cmd.follow || cmd.alloc,
                     !(cmd.follow && cmd.alloc) && !cmd.fail)

endmodule

// ----- rtl/page_table_map_walker_top.sv -----
// Walk: after acceptance each table level takes a registered read, then an evaluate
// and write step; five-level mode walks one more table level than four-level mode.
// The leaf entry is written after the last level, then the result strobe is given;
// a failing walk skips the leaf write. Busy drops the cycle after the strobe, and a new
// request is taken only then, as the table reads depend on each other. Results cannot
// be stalled by the receiver. Reset: a clearing pass then zeroes the whole store.
// ---------------------------------------------------------------------------
// page_table_map_walker_top
// Four or five level page table map walker with a bump allocated table pool.
// ---------------------------------------------------------------------------
module page_table_map_walker_top
   import ptmw_pkg::*;
#(
   parameter int POOL_FRAMES = POOL_FRAMES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [VA_W-1:0]      req_virt_addr,
   input  logic [PA_W-1:0]      req_phys_addr,
   input  logic [PROT_W-1:0]    req_protection,
   output logic                 rsp_valid,
   output logic                 rsp_status,
   output logic [ENTRY_W-1:0]   rsp_leaf_entry,
   output logic [USED_W-1:0]    rsp_frames_used,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BASE_W-1:0]    csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // configuration transfers are always taken
   assign csr_ready = 1'b1;

   ptmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   ptmw_datapath #(
      .POOL_FRAMES (POOL_FRAMES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_protection  (req_protection),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_leaf_entry  (rsp_leaf_entry),
      .rsp_frames_used (rsp_frames_used)
   );

endmodule

// ----- sim/ptmw_mapping_tracker_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptmw_mapping_tracker_pkg
// Mirror of the page table pool and its allocator. Each accepted map request
// is walked here to work out the expected status, leaf entry and frame count,
// and each result from the block is compared against the oldest of these.
// ---------------------------------------------------------------------------
package ptmw_mapping_tracker_pkg;

   import ptmw_pkg::*;

   localparam bit [ENTRY_W-1:0] PT_ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
   localparam int MAX_PRINTED = 100;

   class mapping_tracker;

      typedef struct {
         bit               status;
         bit [ENTRY_W-1:0] leaf_entry;
         bit [USED_W-1:0]  frames_used;
      } map_result_type;

      bit [ENTRY_W-1:0]      table_mirror [POOL_FRAMES_DEF*ENTRIES];
      int unsigned           next_frame;
      bit                    five_level;
      bit [BASE_W-1:0]       pool_base;
      bit [CFG_FRAMES_W-1:0] pool_limit;
      map_result_type        expected_maps [$];
      int                    errors;

      function new();
         foreach (table_mirror[i]) table_mirror[i] = '0;
         next_frame = 1;
         five_level = 1'b0;
         pool_base  = '0;
         pool_limit = POOL_FRAMES_RST;
         errors     = 0;
      endfunction

      function void write_register(bit [CSR_IDX_W-1:0] index, bit [BASE_W-1:0] data);
         case (index)
            CSR_FIVE_LEVEL:  five_level = data[0];
            CSR_POOL_BASE:   pool_base  = data;
            CSR_POOL_FRAMES: pool_limit = data[CFG_FRAMES_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_maps.size();
      endfunction

      static function bit [SLICE_W-1:0] table_index(bit [VA_W-1:0] va, int level);
         bit [VA_W-1:0] shifted;
         shifted = va >> (12 + SLICE_W * (level - 1));
         return shifted[SLICE_W-1:0];
      endfunction

      static function bit [ENTRY_W-1:0] leaf_flags(bit [PROT_W-1:0] prot);
         case (prot)
            PROT_RO:      return F_P | F_NX;
            PROT_RW:      return F_P | F_RW | F_NX;
            PROT_EXEC_RW: return F_P | F_RW;
            PROT_EXEC_RO: return F_P;
            default:      return '0;
         endcase
      endfunction

      // Walk the mirror, allocating missing tables; returns 1 when the leaf was written.
      function bit predict_mapping(bit [VA_W-1:0] va, bit [PA_W-1:0] pa,
                                   bit [PROT_W-1:0] prot);
         int unsigned      limit, frame, pos;
         int               level, i;
         bit [ENTRY_W-1:0] entry, rel, base_wide;
         bit               ok;
         map_result_type   r;
         limit = (pool_limit < POOL_FRAMES_DEF) ? 32'(pool_limit) : POOL_FRAMES_DEF;
         base_wide = ENTRY_W'(pool_base);
         frame = 0;
         ok = 1'b1;
         r.leaf_entry = '0;
         level = five_level ? 5 : 4;
         while (ok && level > 1) begin
            pos = frame * ENTRIES + table_index(va, level);
            entry = table_mirror[pos];
            if (entry[0]) begin
               // a table outside the pool cannot be followed
               rel = ((entry & PT_ADDR_MASK) >> 12) - base_wide;
               if (rel >= POOL_FRAMES_DEF) ok = 1'b0;
               else frame = rel[31:0];
            end else if (next_frame >= limit) begin
               ok = 1'b0;
            end else begin
               for (i = 0; i < ENTRIES; i++) table_mirror[next_frame * ENTRIES + i] = '0;
               table_mirror[pos] = (((base_wide + ENTRY_W'(next_frame)) << 12) & PT_ADDR_MASK)
                                   | F_P | F_RW | F_US;
               frame = next_frame;
               next_frame++;
            end
            level--;
         end
         if (ok) begin
            r.leaf_entry = ENTRY_W'(pa) | leaf_flags(prot);
            table_mirror[frame * ENTRIES + table_index(va, 1)] = r.leaf_entry;
         end
         r.status = !ok;
         r.frames_used = next_frame[USED_W-1:0];
         expected_maps.push_back(r);
         return ok;
      endfunction

      task report_mismatch(string what);
         if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
         errors++;
      endtask

      task check_response(logic status, logic [ENTRY_W-1:0] leaf, logic [USED_W-1:0] used);
         map_result_type r;
         if (expected_maps.size() == 0) begin
            report_mismatch($sformatf("result with none expected: status %b leaf %h used %0d",
                                      status, leaf, used));
         end else begin
            r = expected_maps.pop_front();
            if (status !== r.status)
               report_mismatch($sformatf("status %b, expected %b", status, r.status));
            if (leaf !== r.leaf_entry)
               report_mismatch($sformatf("leaf_entry %h, expected %h", leaf, r.leaf_entry));
            if (used !== r.frames_used)
               report_mismatch($sformatf("frames_used %0d, expected %0d", used,
                                         r.frames_used));
         end
      endtask

      task check_drained();
         if (expected_maps.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_maps.size()));
      endtask

   endclass

endpackage

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives map requests into the page table map walker under several mode,
// pool base and pool size settings, and checks every result against a
// mirrored walk of the table pool.
// ---------------------------------------------------------------------------
module testbench;

   import ptmw_pkg::*;
   import ptmw_mapping_tracker_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      bit [VA_W-1:0]   va;
      bit              five_level;
      bit [BASE_W-1:0] base;
   } mapped_va_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [VA_W-1:0]      req_virt_addr;
   logic [PA_W-1:0]      req_phys_addr;
   logic [PROT_W-1:0]    req_protection;
   logic                 rsp_valid;
   logic                 rsp_status;
   logic [ENTRY_W-1:0]   rsp_leaf_entry;
   logic [USED_W-1:0]    rsp_frames_used;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BASE_W-1:0]    csr_wdata;

   mapping_tracker tracker = new();
   mapped_va_type  mapped_vas [$];

   page_table_map_walker_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_virt_addr   (req_virt_addr),
      .req_phys_addr   (req_phys_addr),
      .req_protection  (req_protection),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_leaf_entry  (rsp_leaf_entry),
      .rsp_frames_used (rsp_frames_used),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         tracker.check_response(rsp_status, rsp_leaf_entry, rsp_frames_used);
   end

   function automatic bit [VA_W-1:0] rand_va();
      return VA_W'({$urandom, $urandom});
   endfunction

   function automatic bit [PA_W-1:0] rand_pa();
      return PA_W'({$urandom, $urandom});
   endfunction

   // called at a falling edge, returns at a falling edge with start still high
   task automatic send_item(bit [VA_W-1:0] va, bit [PA_W-1:0] pa, bit [PROT_W-1:0] prot);
      mapped_va_type m;
      start = 1'b1;
      req_virt_addr = va;
      req_phys_addr = pa;
      req_protection = prot;
      do @(posedge clock); while (busy !== 1'b0);
      if (tracker.predict_mapping(va, pa, prot)) begin
         m.va = va;
         m.five_level = tracker.five_level;
         m.base = tracker.pool_base;
         mapped_vas.push_back(m);
      end
      @(negedge clock);
   endtask

   task automatic wait_idle();
      start = 1'b0;
      do @(negedge clock); while (tracker.pending() != 0 || busy !== 1'b0);
   endtask

   task automatic write_csr(bit [CSR_IDX_W-1:0] index, bit [BASE_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.write_register(index, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Mostly reuse paths already mapped under the current setting, so walks get past
   // the upper levels once the pool is spent; the rest are fresh addresses.
   function automatic bit [VA_W-1:0] pick_va(int fresh_pct);
      bit [VA_W-1:0] va;
      int            idx, tries;
      va = rand_va();
      if (mapped_vas.size() == 0 || $urandom_range(0, 99) < fresh_pct) return va;
      idx = $urandom_range(0, mapped_vas.size() - 1);
      tries = 0;
      while (tries < 8 && (mapped_vas[idx].five_level != tracker.five_level ||
                           mapped_vas[idx].base != tracker.pool_base)) begin
         idx = $urandom_range(0, mapped_vas.size() - 1);
         tries++;
      end
      va[VA_W-1:12] = mapped_vas[idx].va[VA_W-1:12];
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9: va[20:12] = SLICE_W'($urandom);
         15:                           va[29:12] = 18'($urandom);
         default: ;
      endcase
      // upper slice is ignored in four-level mode
      if (!tracker.five_level && $urandom_range(0, 1)) va[56:48] = SLICE_W'($urandom);
      return va;
   endfunction

   task automatic run_random(int count, int fresh_pct);
      int sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 12);
         while (burst > 0 && sent < count) begin
            send_item(pick_va(fresh_pct), rand_pa(), PROT_W'($urandom_range(0, 7)));
            burst--;
            sent++;
         end
         gap = $urandom_range(0, 15);
         if ($urandom_range(0, 9) == 0) begin
            wait_idle();
         end else if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      start = 1'b0;
   endtask

   initial begin : stimulus
      bit [VA_W-1:0] va;
      int            k;
      reset = 1'b1;
      start = 1'b0;
      req_virt_addr = '0;
      req_phys_addr = '0;
      req_protection = PROT_RO;
      csr_valid = 1'b0;
      csr_index = CSR_FIVE_LEVEL;
      csr_wdata = '0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // four-level, pool at frame zero, full pool
      write_csr(CSR_FIVE_LEVEL, {$urandom, 8'd0});
      write_csr(CSR_POOL_BASE, '0);
      write_csr(CSR_POOL_FRAMES, {$urandom, 8'd64});
      send_item('0, '0, PROT_RO);
      send_item('0, '1, PROT_RW);
      send_item('1, rand_pa(), PROT_EXEC_RW);
      send_item({{(VA_W-21){1'b1}}, 21'd0}, rand_pa(), PROT_EXEC_RO);
      for (k = 0; k < 8; k++) begin
         va = VA_W'(k);
         send_item(va << 12, rand_pa(), PROT_W'(k));
      end
      // aliases the zero address while the top slice is unused
      send_item({9'h1FF, 48'd0}, rand_pa(), PROT_RO);
      run_random(120, 5);

      // limit below what is allocated: only existing paths can map
      wait_idle();
      write_csr(CSR_POOL_FRAMES, {$urandom, 8'd1});
      send_item(rand_va(), rand_pa(), PROT_RW);
      send_item('0, rand_pa(), PROT_EXEC_RW);
      run_random(30, 30);

      wait_idle();
      write_csr(CSR_POOL_FRAMES, {$urandom, 8'd0});
      write_csr(CSR_SPARE, {$urandom, 8'($urandom)});
      send_item('1, rand_pa(), PROT_RO);
      send_item(rand_va(), rand_pa(), PROT_RO);

      // base at its top: earlier tables fall outside the pool, new ones wrap
      wait_idle();
      write_csr(CSR_POOL_FRAMES, {$urandom, 8'd64});
      write_csr(CSR_POOL_BASE, '1);
      va = rand_va();
      send_item(va, rand_pa(), PROT_RW);
      send_item(va, rand_pa(), PROT_RO);
      run_random(20, 10);

      wait_idle();
      write_csr(CSR_FIVE_LEVEL, {$urandom, 8'd1});
      write_csr(CSR_POOL_BASE, {$urandom, 8'($urandom)});
      run_random(20, 10);

      // five-level over the original pool
      wait_idle();
      write_csr(CSR_POOL_BASE, '0);
      send_item('1, rand_pa(), PROT_EXEC_RO);
      send_item('0, rand_pa(), PROT_RW);
      send_item({9'h001, 48'd0}, rand_pa(), PROT_EXEC_RW);
      run_random(80, 5);

      wait_idle();
      write_csr(CSR_FIVE_LEVEL, {$urandom, 8'd0});
      write_csr(CSR_POOL_FRAMES, {$urandom, 1'b0, 7'($urandom_range(2, 63))});
      run_random(50, 20);
      wait_idle();
      write_csr(CSR_POOL_FRAMES, {$urandom, 8'd64});
      run_random(60, 20);

      wait_idle();
      repeat (16) @(negedge clock);
      tracker.check_drained();
      if (tracker.errors == 0) $display("** page_table_map_walker_top: PASSED **");
      else $display("** page_table_map_walker_top: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("** page_table_map_walker_top: FAILED **");
      $finish;
   end

endmodule
